// File: sv/mmq_pkg.sv
package mmq_pkg;

  // Bits of each car count that take part in the arbitration.
  localparam int unsigned COUNT_WIDTH = 8;
  localparam int unsigned FieldW      = 8;
  localparam int unsigned CntW        = (COUNT_WIDTH < FieldW) ? COUNT_WIDTH : FieldW;
  localparam int unsigned NumRoads    = 4;
  localparam int unsigned RoadW       = 2;
  localparam int unsigned SumW        = CntW + 2;
  localparam int unsigned CfgW        = 8;
  localparam int unsigned ProdW       = CntW + CfgW;
  localparam int unsigned StepW       = $clog2(ProdW + 1);
  localparam int unsigned GreenW      = 8;

  localparam logic [1:0] RegCycleTime = 2'd0;
  localparam logic [1:0] RegMinGreen  = 2'd1;

  localparam logic [CfgW-1:0] CycleTimeRst = 8'd60;
  localparam logic [CfgW-1:0] MinGreenRst  = 8'd5;

  typedef struct packed {
    logic            eligible;
    logic [CntW-1:0] count;
  } lane_t;

  typedef struct packed {
    logic            eligible;
    logic [RoadW-1:0] road;
    logic [CntW-1:0] count;
  } pick_t;

endpackage

// File: sv/mmq_lane.sv
module mmq_lane import mmq_pkg::*; (
  input  logic [FieldW-1:0] cars_i,
  input  logic              served_i,
  output lane_t             lane_o
);

  assign lane_o.eligible = ~served_i;
  assign lane_o.count    = cars_i[CntW-1:0];

endmodule

// File: sv/mmq_merge.sv
module mmq_merge import mmq_pkg::*; (
  input  lane_t [NumRoads-1:0] lanes_i,
  output pick_t                pick_o
);

  function automatic pick_t better(pick_t a, pick_t b);
    // The lower-indexed side a wins ties.
    if (a.eligible && (!b.eligible || a.count <= b.count)) begin
      return a;
    end
    return b;
  endfunction

  pick_t [NumRoads-1:0] leaf;
  pick_t                lo_pick;
  pick_t                hi_pick;

  always_comb begin
    for (int i = 0; i < NumRoads; i++) begin
      leaf[i].eligible = lanes_i[i].eligible;
      leaf[i].road     = RoadW'(i);
      leaf[i].count    = lanes_i[i].count;
    end
    lo_pick = better(leaf[0], leaf[1]);
    hi_pick = better(leaf[2], leaf[3]);
    pick_o  = better(lo_pick, hi_pick);
  end

endmodule

// File: sv/mmq_divider.sv
module mmq_divider import mmq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ProdW-1:0] dividend_i,
  input  logic [SumW-1:0]  divisor_i,
  output logic             done_o,
  output logic [ProdW-1:0] quotient_o
);

  logic [StepW-1:0] step_q, step_d;
  logic             done_q, done_d;
  logic [ProdW-1:0] quot_q, quot_d;
  logic [SumW-1:0]  rem_q, rem_d;
  logic [SumW-1:0]  dvs_q, dvs_d;
  logic [SumW:0]    trial;

  always_comb begin
    step_d = step_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[ProdW-1]};
    if (start_i) begin
      step_d = StepW'(ProdW);
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (step_q != '0) begin
      // One dividend bit per cycle; quotient bits shift in behind it.
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = SumW'(trial - {1'b0, dvs_q});
        quot_d = {quot_q[ProdW-2:0], 1'b1};
      end else begin
        rem_d  = trial[SumW-1:0];
        quot_d = {quot_q[ProdW-2:0], 1'b0};
      end
      step_d = step_q - StepW'(1);
      done_d = (step_q == StepW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

// File: sv/masked_min_queue_green_arbiter_core.sv
// Green phase arbiter for four approaches. Each input item carries the queued
// car counts of north, east, south and west; the block grants the unserved
// approach with the fewest cars (lowest index on ties), marks it served, and
// restarts the served mask once all four have had green. The green time is
// floor(count * cycle_time / (1 + sum of counts)), raised to min_green. An
// item passes these steps from one accept to the next: arbitrate, multiply
// and load the divider, divide in the bit-serial divider one dividend bit at
// a time, take the quotient, and load the output register, which waits until
// the previous result has been taken. The next item is taken once the result
// has moved to the output register, even if it has not been taken yet.
module masked_min_queue_green_arbiter_core import mmq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cars_north [7:0], cars_east [15:8], cars_south [23:16], cars_west [31:24]
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // granted_road [1:0], green_seconds [9:2], mask_was_cleared [10], zero [15:11]
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [NumRoads-1:0] mask_q, mask_d;
  logic [CfgW-1:0]    cycle_q, min_q;
  logic               in_acc;
  logic               out_free;

  logic [NumRoads-1:0] mask_eff;
  logic                clear_now;
  lane_t [NumRoads-1:0] lanes;
  pick_t               pick;
  logic [SumW-1:0]     sum;

  logic [RoadW-1:0]  road_q;
  logic [CntW-1:0]   cnt_q;
  logic [SumW-1:0]   sum_q;
  logic              clr_q;
  logic [GreenW-1:0] green_q;

  logic              div_start;
  logic              div_done;
  logic [ProdW-1:0]  quot;
  logic [ProdW-1:0]  product;

  logic              out_valid_q, out_valid_d;
  logic [15:0]       out_data_q;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign clear_now = &mask_q;
  assign mask_eff  = clear_now ? '0 : mask_q;

  for (genvar g = 0; g < NumRoads; g++) begin : g_lane
    mmq_lane u_lane (
      .cars_i   (s_axis_tdata[g*FieldW +: FieldW]),
      .served_i (mask_eff[g]),
      .lane_o   (lanes[g])
    );
  end

  mmq_merge u_merge (
    .lanes_i (lanes),
    .pick_o  (pick)
  );

  always_comb begin
    sum = '0;
    for (int i = 0; i < NumRoads; i++) begin
      sum = sum + SumW'(lanes[i].count);
    end
  end

  assign product   = ProdW'(cnt_q) * ProdW'(cycle_q);
  assign div_start = (state_q == S_MUL);

  mmq_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (sum_q + SumW'(1)),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d     = state_q;
    mask_d      = mask_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          mask_d  = mask_eff | (NumRoads'(1) << pick.road);
          state_d = S_MUL;
        end
      end
      S_MUL: state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
      cycle_q     <= CycleTimeRst;
      min_q       <= MinGreenRst;
    end else begin
      state_q     <= state_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && cfg_addr_i == RegCycleTime) begin
        cycle_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_addr_i == RegMinGreen) begin
        min_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      road_q <= pick.road;
      cnt_q  <= pick.count;
      sum_q  <= sum;
      clr_q  <= clear_now;
    end
    // The quotient never exceeds cycle_time, so its low byte is exact.
    if (state_q == S_DIV && div_done) begin
      green_q <= (quot[GreenW-1:0] < min_q) ? min_q : quot[GreenW-1:0];
    end
    if (state_q == S_OUT && out_free) begin
      out_data_q <= {5'b0, clr_q, green_q, road_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_MUL))
    else $error("accepted item did not start the multiply step");

  a_mask_marked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (mask_q != '0))
    else $error("served mask empty after a grant");

  a_green_floor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> (green_q >= min_q))
    else $error("green time below min_green");

  a_div_only_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

endmodule

// File: verif/tb_masked_min_queue_green_arbiter_core.sv
`timescale 1ns / 1ps

module tb_masked_min_queue_green_arbiter_core;
  import mmq_pkg::*;

  // Register indexes past the last real register; writes to them must be dropped.
  localparam logic [1:0] RegSpareA = 2'd2;
  localparam logic [1:0] RegSpareB = 2'd3;

  localparam int unsigned ItemCycles  = ProdW + 4;
  localparam int unsigned DrainCycles = 2 * ItemCycles + 8;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned RandPerSet  = 92;

  typedef struct packed {
    logic             cleared;
    logic [GreenW-1:0] green;
    logic [RoadW-1:0] road;
  } grant_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = '0;
  logic [7:0]  cfg_wdata_i = '0;

  // Predictor state: the served mask and the two registers.
  logic [NumRoads-1:0] served_q;
  logic [CfgW-1:0]     cycle_q;
  logic [CfgW-1:0]     min_green_q;

  grant_t grant_q[$];
  grant_t exp_grant;
  grant_t got_grant;

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_clears = 0;
  int unsigned n_cfg = 0;
  int unsigned n_err = 0;
  int unsigned stall_cnt = 0;

  masked_min_queue_green_arbiter_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic grant_t predict_grant(input logic [31:0] cars);
    int unsigned cnt[NumRoads];
    int unsigned sum;
    int unsigned best;
    int unsigned best_cnt;
    int unsigned quo;
    bit          found;
    grant_t      g;
    sum = 0;
    best = 0;
    best_cnt = 0;
    found = 1'b0;
    g = '0;
    for (int i = 0; i < NumRoads; i++) begin
      cnt[i] = cars[i*FieldW +: FieldW] & ((1 << CntW) - 1);
      sum += cnt[i];
    end
    if (served_q == '1) begin
      served_q = '0;
      g.cleared = 1'b1;
    end
    for (int i = 0; i < NumRoads; i++) begin
      if (!served_q[i] && (!found || cnt[i] < best_cnt)) begin
        best = i;
        best_cnt = cnt[i];
        found = 1'b1;
      end
    end
    served_q[best[RoadW-1:0]] = 1'b1;
    quo = (best_cnt * cycle_q) / (sum + 1);
    if (quo < min_green_q) quo = 32'(min_green_q);
    g.road = best[RoadW-1:0];
    g.green = quo[GreenW-1:0];
    return g;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (n_err < 10) begin
      $display("%0t: %s mismatch on result %0d: expected %0d, got %0d",
               $realtime, what, n_results, want, got);
    end
    n_err++;
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Each result is compared with the oldest outstanding grant.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_grant = m_axis_tdata[10:0];
      if (grant_q.size() == 0) begin
        if (n_err < 10) begin
          $display("%0t: result 0x%0h arrived with nothing outstanding",
                   $realtime, m_axis_tdata);
        end
        n_err++;
      end else begin
        exp_grant = grant_q.pop_front();
        if (got_grant.road !== exp_grant.road)
          report_mismatch("granted_road", 32'(exp_grant.road), 32'(got_grant.road));
        if (got_grant.green !== exp_grant.green)
          report_mismatch("green_seconds", 32'(exp_grant.green), 32'(got_grant.green));
        if (got_grant.cleared !== exp_grant.cleared)
          report_mismatch("mask_was_cleared", 32'(exp_grant.cleared),
                          32'(got_grant.cleared));
        if (m_axis_tdata[15:11] !== '0)
          report_mismatch("padding", 0, 32'(m_axis_tdata[15:11]));
        if (exp_grant.cleared) n_clears++;
      end
      n_results++;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= StallLimit) begin
      $display("%0t: no item moved for %0d cycles", $realtime, StallLimit);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_cars(input logic [7:0] north, input logic [7:0] east,
                           input logic [7:0] south, input logic [7:0] west);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {west, south, east, north};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    grant_q.push_back(predict_grant({west, south, east, north}));
    n_items++;
  endtask

  // Holds the sender off until every outstanding grant has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegCycleTime: cycle_q = val;
      RegMinGreen:  min_green_q = val;
      default: ;
    endcase
    n_cfg++;
    @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    // All counts zero gives a zero quotient, which is raised to min_green.
    send_cars(8'd0, 8'd0, 8'd0, 8'd0);
    send_cars(8'd255, 8'd255, 8'd255, 8'd255);
    send_cars(8'd10, 8'd3, 8'd3, 8'd7);
    send_cars(8'd1, 8'd1, 8'd1, 8'd1);
    // The mask is full here, so this item restarts it; east and west tie.
    send_cars(8'd200, 8'd5, 8'd9, 8'd5);
    send_cars(8'd0, 8'd255, 8'd0, 8'd255);
    send_cars(8'haa, 8'h55, 8'haa, 8'h55);
    send_cars(8'h55, 8'haa, 8'h55, 8'haa);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    cfg_write(RegCycleTime, 8'd255);
    cfg_write(RegMinGreen, 8'd0);
    send_cars(8'd255, 8'd0, 8'd0, 8'd0);
    send_cars(8'd255, 8'd254, 8'd1, 8'd0);
    send_cars(8'd128, 8'd127, 8'd64, 8'd255);
    send_cars(8'd255, 8'd255, 8'd255, 8'd255);
    wait_drained();
    // A zero cycle time is outside the stated range but still writable.
    cfg_write(RegCycleTime, 8'd0);
    cfg_write(RegMinGreen, 8'd7);
    send_cars(8'd9, 8'd200, 8'd3, 8'd90);
    send_cars(8'd0, 8'd0, 8'd0, 8'd0);
    wait_drained();
    cfg_write(RegCycleTime, 8'd1);
    cfg_write(RegMinGreen, 8'd255);
    send_cars(8'd20, 8'd30, 8'd40, 8'd50);
    send_cars(8'd255, 8'd255, 8'd0, 8'd255);
    wait_drained();
    // Writes to indexes beyond the last register must leave both untouched.
    cfg_write(RegCycleTime, 8'd200);
    cfg_write(RegMinGreen, 8'd0);
    cfg_write(RegSpareA, 8'd1);
    cfg_write(RegSpareB, 8'd255);
    send_cars(8'd100, 8'd50, 8'd25, 8'd12);
    send_cars(8'd7, 8'd7, 8'd7, 8'd7);
    send_cars(8'd255, 8'd1, 8'd2, 8'd3);
    wait_drained();
  endtask

  function automatic logic [7:0] pick_count(input logic [7:0] tie);
    case ($urandom_range(3))
      0: return 8'($urandom_range(255));
      1: return 8'($urandom_range(7));
      2: return 8'd255 - 8'($urandom_range(7));
      default: return tie;
    endcase
  endfunction

  task automatic pick_registers();
    case ($urandom_range(5))
      0: cfg_write(RegCycleTime, 8'd255);
      1: cfg_write(RegCycleTime, 8'd1);
      default: cfg_write(RegCycleTime, 8'($urandom_range(1, 255)));
    endcase
    case ($urandom_range(5))
      0: cfg_write(RegMinGreen, 8'd0);
      1: cfg_write(RegMinGreen, 8'd255);
      default: cfg_write(RegMinGreen, 8'($urandom_range(20)));
    endcase
  endtask

  task automatic test_random_phase(input int unsigned snd_pct, input int unsigned rcv_pct);
    logic [7:0] tie;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    for (int s = 0; s < 3; s++) begin
      pick_registers();
      for (int k = 0; k < RandPerSet; k++) begin
        tie = 8'($urandom_range(255));
        send_cars(pick_count(tie), pick_count(tie), pick_count(tie), pick_count(tie));
      end
      wait_drained();
    end
  endtask

  initial begin
    served_q    = '0;
    cycle_q     = CycleTimeRst;
    min_green_q = MinGreenRst;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_register_extremes();
    test_random_phase(25, 88);
    test_random_phase(88, 25);
    test_random_phase(0, 0);

    $display("Sent %0d items and checked %0d grants, %0d of them mask restarts,",
             n_items, n_results, n_clears);
    $display("over %0d register writes spanning the extremes of both registers.", n_cfg);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", n_err);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/mmq_pkg.sv
sv/mmq_lane.sv
sv/mmq_merge.sv
sv/mmq_divider.sv
sv/masked_min_queue_green_arbiter_core.sv
verif/tb_masked_min_queue_green_arbiter_core.sv
